// ===== rtl/i2c_master_byte_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master byte engine - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// property checked at every rising clock edge out of reset
`define I2C_MBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold whenever a request is on the output channel
`define I2C_MBE_ASSERT_OUT(label, cond, msg) \
    `I2C_MBE_ASSERT(label, out_valid |-> (cond), msg)

`endif

// ===== rtl/i2c_mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine - package
// Request and result types, command codes and sequencer constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2c_mbe_pkg;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       scl_drive;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_level;
        logic       cmd_rejected;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_byte_engine_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine - top level
// Command-driven I2C master: start, stop, write byte, read byte, tick.
// ----------------------------------------------------------------------------
// Every accepted request gives exactly one result, held first in the input
// register and then in the result register. One request is taken per clock
// cycle while the result side keeps up; the phase, shift and line state are
// updated together as each request advances, which allows that rate. Ticks
// pace the bus: each bus phase lasts half_period_ticks tick
// requests (a value of 0 acts as 1). A command given while a sequence runs is
// ignored and flagged with cmd_rejected; unknown kinds only report status.
// Write half_period_ticks through cfg_we/cfg_wdata only while the engine is
// idle and no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        send_ack,
    input  wire logic        sda_in,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             scl_level,
    output logic             scl_drive,
    output logic             sda_level,
    output logic             sda_drive,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       read_byte,
    output logic             ack_level,
    output logic             cmd_rejected
);

    logic               in_vld_reg, in_vld_next;
    i2c_mbe_pkg::item_t item_reg;
    logic               out_vld_reg, out_vld_next;
    i2c_mbe_pkg::res_t  res_reg;
    i2c_mbe_pkg::res_t  res_step;
    logic               advance;
    logic               in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : ((out_vld_reg && !out_stall) ? 1'b0 : out_vld_reg);

    i2c_mbe_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .item      (item_reg),
        .res       (res_step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind      <= kind;
            item_reg.data_byte <= data_byte;
            item_reg.send_ack  <= send_ack;
            item_reg.sda_in    <= sda_in;
        end
        if (advance)
            res_reg <= res_step;
    end

    assign out_valid    = out_vld_reg;
    assign scl_level    = res_reg.scl_level;
    assign scl_drive    = res_reg.scl_drive;
    assign sda_level    = res_reg.sda_level;
    assign sda_drive    = res_reg.sda_drive;
    assign busy_res     = res_reg.busy_res;
    assign done_res     = res_reg.done_res;
    assign read_byte    = res_reg.read_byte;
    assign ack_level    = res_reg.ack_level;
    assign cmd_rejected = res_reg.cmd_rejected;

endmodule

`default_nettype wire

// ===== rtl/i2c_mbe_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine - bus sequencer
// Phase state, bit shifter and line registers; one request per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_mbe_seq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               step_en,
    input  wire i2c_mbe_pkg::item_t item,
    output i2c_mbe_pkg::res_t       res
);

    logic [15:0] half_reg;
    logic [1:0]  phase_reg,  phase_next;
    logic [15:0] tick_reg,   tick_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [3:0]  bitcnt_reg, bitcnt_next;
    logic [1:0]  op_reg,     op_next;
    logic        ackch_reg,  ackch_next;
    logic        acksmp_reg, acksmp_next;
    logic        scl_lvl_reg, scl_lvl_next;
    logic        scl_drv_reg, scl_drv_next;
    logic        sda_lvl_reg, sda_lvl_next;
    logic        sda_drv_reg, sda_drv_next;
    logic [7:0]  rdbyte_reg, rdbyte_next;

    logic [15:0] limit;
    logic [15:0] tick_inc;
    logic [3:0]  bit_inc;
    logic        done;
    logic        rejected;

    assign limit    = (half_reg == 16'd0) ? 16'd1 : half_reg;
    assign tick_inc = tick_reg + 16'd1;
    assign bit_inc  = bitcnt_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        bitcnt_next  = bitcnt_reg;
        op_next      = op_reg;
        ackch_next   = ackch_reg;
        acksmp_next  = acksmp_reg;
        scl_lvl_next = scl_lvl_reg;
        scl_drv_next = scl_drv_reg;
        sda_lvl_next = sda_lvl_reg;
        sda_drv_next = sda_drv_reg;
        rdbyte_next  = rdbyte_reg;
        done         = 1'b0;
        rejected     = 1'b0;

        if (step_en)
        begin
            priority if (item.kind == i2c_mbe_pkg::KIND_TICK)
            begin
                if (phase_reg != i2c_mbe_pkg::PH_IDLE)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= limit)
                    begin
                        tick_next = 16'd0;
                        unique case (op_reg)
                            i2c_mbe_pkg::OP_START:
                            begin
                                if (phase_reg == i2c_mbe_pkg::PH_ONE)
                                begin
                                    sda_lvl_next = 1'b0;
                                    phase_next   = i2c_mbe_pkg::PH_TWO;
                                end
                                else
                                begin
                                    scl_lvl_next = 1'b0;
                                    done         = 1'b1;
                                end
                            end
                            i2c_mbe_pkg::OP_STOP:
                            begin
                                if (phase_reg == i2c_mbe_pkg::PH_ONE)
                                begin
                                    scl_lvl_next = 1'b1;
                                    phase_next   = i2c_mbe_pkg::PH_TWO;
                                end
                                else
                                begin
                                    sda_lvl_next = 1'b1;
                                    done         = 1'b1;
                                end
                            end
                            i2c_mbe_pkg::OP_WRITE, i2c_mbe_pkg::OP_READ:
                            begin
                                if (phase_reg == i2c_mbe_pkg::PH_ONE)
                                begin
                                    if (bitcnt_reg >= i2c_mbe_pkg::BITS_PER_BYTE)
                                    begin
                                        if (op_reg == i2c_mbe_pkg::OP_WRITE)
                                            acksmp_next = item.sda_in;
                                    end
                                    else if (op_reg == i2c_mbe_pkg::OP_READ)
                                    begin
                                        shift_next = {shift_reg[6:0], item.sda_in};
                                    end
                                    scl_lvl_next = 1'b0;
                                    phase_next   = i2c_mbe_pkg::PH_TWO;
                                end
                                else if (bitcnt_reg >= i2c_mbe_pkg::BITS_PER_BYTE)
                                begin
                                    if (op_reg == i2c_mbe_pkg::OP_WRITE)
                                        sda_drv_next = 1'b1;
                                    done = 1'b1;
                                end
                                else
                                begin
                                    bitcnt_next = bit_inc;
                                    if (op_reg == i2c_mbe_pkg::OP_WRITE)
                                    begin
                                        if (bit_inc < i2c_mbe_pkg::BITS_PER_BYTE)
                                        begin
                                            shift_next   = {shift_reg[6:0], 1'b0};
                                            sda_lvl_next = shift_reg[6];
                                        end
                                        else
                                        begin
                                            sda_lvl_next = 1'b1;
                                            sda_drv_next = 1'b0;
                                        end
                                    end
                                    else if (bit_inc >= i2c_mbe_pkg::BITS_PER_BYTE)
                                    begin
                                        rdbyte_next  = shift_reg;
                                        sda_drv_next = 1'b1;
                                        sda_lvl_next = ~ackch_reg;
                                    end
                                    scl_lvl_next = 1'b1;
                                    phase_next   = i2c_mbe_pkg::PH_ONE;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                        if (done)
                            phase_next = i2c_mbe_pkg::PH_IDLE;
                    end
                end
            end
            else if (item.kind <= i2c_mbe_pkg::KIND_READ)
            begin
                if (phase_reg != i2c_mbe_pkg::PH_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    op_next     = 2'(item.kind - 3'd1);
                    phase_next  = i2c_mbe_pkg::PH_ONE;
                    tick_next   = 16'd0;
                    bitcnt_next = 4'd0;
                    unique case (op_next)
                        i2c_mbe_pkg::OP_START:
                        begin
                            scl_drv_next = 1'b1;
                            sda_drv_next = 1'b1;
                            sda_lvl_next = 1'b1;
                            scl_lvl_next = 1'b1;
                        end
                        i2c_mbe_pkg::OP_STOP:
                        begin
                            sda_lvl_next = 1'b0;
                        end
                        i2c_mbe_pkg::OP_WRITE:
                        begin
                            shift_next   = item.data_byte;
                            sda_lvl_next = item.data_byte[7];
                            scl_lvl_next = 1'b1;
                        end
                        default:
                        begin
                            ackch_next   = item.send_ack;
                            shift_next   = 8'd0;
                            sda_lvl_next = 1'b1;
                            sda_drv_next = 1'b0;
                            scl_lvl_next = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                rejected = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= i2c_mbe_pkg::HALF_PERIOD_RESET;
            phase_reg   <= i2c_mbe_pkg::PH_IDLE;
            tick_reg    <= 16'd0;
            shift_reg   <= 8'd0;
            bitcnt_reg  <= 4'd0;
            op_reg      <= i2c_mbe_pkg::OP_START;
            ackch_reg   <= 1'b0;
            acksmp_reg  <= 1'b1;
            scl_lvl_reg <= 1'b1;
            scl_drv_reg <= 1'b0;
            sda_lvl_reg <= 1'b1;
            sda_drv_reg <= 1'b0;
            rdbyte_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_we)
                half_reg <= cfg_wdata;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            bitcnt_reg  <= bitcnt_next;
            op_reg      <= op_next;
            ackch_reg   <= ackch_next;
            acksmp_reg  <= acksmp_next;
            scl_lvl_reg <= scl_lvl_next;
            scl_drv_reg <= scl_drv_next;
            sda_lvl_reg <= sda_lvl_next;
            sda_drv_reg <= sda_drv_next;
            rdbyte_reg  <= rdbyte_next;
        end
    end

    always_comb
    begin
        res.scl_level    = scl_lvl_next;
        res.scl_drive    = scl_drv_next;
        res.sda_level    = sda_lvl_next;
        res.sda_drive    = sda_drv_next;
        res.busy_res     = (phase_next != i2c_mbe_pkg::PH_IDLE);
        res.done_res     = done;
        res.read_byte    = rdbyte_next;
        res.ack_level    = acksmp_next;
        res.cmd_rejected = rejected;
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_mbe_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine - port checker
// Result status consistency and output hold, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_unit_macros.svh"

module i2c_mbe_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] read_byte,
    input wire logic       cmd_rejected
);

    `I2C_MBE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(read_byte), "stalled result changed")
    `I2C_MBE_ASSERT_OUT(a_done_idle, !(done_res && busy_res), "done while still busy")
    `I2C_MBE_ASSERT_OUT(a_reject_busy, !cmd_rejected || busy_res, "rejection while idle")
    `I2C_MBE_ASSERT_OUT(a_done_reject, !(done_res && cmd_rejected), "done and rejected together")

endmodule

bind i2c_master_byte_engine_unit i2c_mbe_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_byte    (read_byte),
    .cmd_rejected (cmd_rejected)
);

`default_nettype wire
